// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define SFD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SFD_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/sfd_pkg.sv -----
// Shared types, event codes and the CRC-8 step for the serial frame deframer.
// No dependencies.
`timescale 1ns / 1ps

package sfd_pkg;

   localparam logic [1:0] EV_GOOD     = 2'd0;
   localparam logic [1:0] EV_CRC_FAIL = 2'd1;
   localparam logic [1:0] EV_LEN_REJ  = 2'd2;
   localparam logic [1:0] EV_OVERFLOW = 2'd3;

   localparam logic [7:0] CRC_POLY    = 8'hD5;
   localparam logic [7:0] MIN_LEN     = 8'd2;
   localparam logic [7:0] MAX_LEN_RST = 8'd62;

   // One entry of the front-to-back queue: what to emit and the totals to report.
   typedef struct packed {
      logic [1:0]  code;
      logic [6:0]  total;
      logic        bank;
      logic [31:0] good;
      logic [31:0] crc_fail;
      logic [31:0] len_rej;
      logic [31:0] ovf;
   } ev_type;

   // CRC-8, MSB first, no reflection, one byte.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/sfd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sfd_front.sv -----
// Front end: parses incoming bytes, runs the CRC, fills the frame banks,
// keeps the event totals and queues one event per finished frame or error. Uses sfd_pkg.
`timescale 1ns / 1ps

module sfd_front import sfd_pkg::*; #(
   parameter int BUF_DEPTH   = 64,
   parameter int COUNT_WIDTH = 32,
   localparam int IDX_W  = $clog2(BUF_DEPTH),
   localparam int FILL_W = $clog2(BUF_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_in_byte,
   input  logic             q_full,
   output logic             q_push,
   output ev_type           q_ev,
   input  logic [1:0]       bank_release,
   output logic             mem_wr_en,
   output logic [IDX_W:0]   mem_wr_addr,
   output logic [7:0]       mem_wr_data
);

   localparam logic [1:0] PH_ADDR = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   logic [7:0]             max_len_ff;
   logic [1:0]             phase_ff, phase_in, eff_phase;
   logic [FILL_W-1:0]      fill_ff, fill_in, fill_nx;
   logic [7:0]             target_ff, target_in;
   logic [7:0]             crc_ff, crc_in;
   logic                   wbank_ff, wbank_in;
   logic [1:0]             busy_ff, busy_in, busy_set;
   logic [COUNT_WIDTH-1:0] good_ff, good_in;
   logic [COUNT_WIDTH-1:0] crcf_ff, crcf_in;
   logic [COUNT_WIDTH-1:0] lrej_ff, lrej_in;
   logic [COUNT_WIDTH-1:0] ovf_ff, ovf_in;
   logic [IDX_W-1:0]       wr_idx;
   logic                   accept;

   assign req_ready = !q_full && !busy_ff[wbank_ff];
   assign accept    = req_valid && req_ready;
   assign fill_nx   = fill_ff + 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      fill_in   = fill_ff;
      target_in = target_ff;
      crc_in    = crc_ff;
      wbank_in  = wbank_ff;
      good_in   = good_ff;
      crcf_in   = crcf_ff;
      lrej_in   = lrej_ff;
      ovf_in    = ovf_ff;
      busy_set  = 2'b00;
      q_push    = 1'b0;
      q_ev      = '0;
      mem_wr_en = 1'b0;
      wr_idx    = '0;
      eff_phase = phase_ff;
      if (accept) begin
         // a full buffer drops the frame; the byte then starts a new one
         if (phase_ff == PH_BODY && fill_ff >= FILL_W'(BUF_DEPTH)) begin
            ovf_in    = ovf_ff + 1'b1;
            q_push    = 1'b1;
            q_ev.code = EV_OVERFLOW;
            eff_phase = PH_ADDR;
         end
         mem_wr_en = 1'b1;
         unique case (eff_phase)
            PH_LEN: begin
               wr_idx = IDX_W'(1);
               if (req_in_byte >= MIN_LEN && req_in_byte <= max_len_ff) begin
                  target_in = req_in_byte;
                  fill_in   = FILL_W'(2);
                  crc_in    = 8'd0;
                  phase_in  = PH_BODY;
               end else begin
                  lrej_in   = lrej_ff + 1'b1;
                  q_push    = 1'b1;
                  q_ev.code = EV_LEN_REJ;
                  phase_in  = PH_ADDR;
                  fill_in   = '0;
                  target_in = 8'd0;
                  crc_in    = 8'd0;
               end
            end
            PH_BODY: begin
               wr_idx  = fill_ff[IDX_W-1:0];
               fill_in = fill_nx;
               if (9'(fill_nx) == ({1'b0, target_ff} + 9'd2)) begin
                  q_push    = 1'b1;
                  phase_in  = PH_ADDR;
                  fill_in   = '0;
                  target_in = 8'd0;
                  crc_in    = 8'd0;
                  if (req_in_byte == crc_ff) begin
                     good_in            = good_ff + 1'b1;
                     q_ev.code          = EV_GOOD;
                     q_ev.total         = 7'(fill_nx);
                     q_ev.bank          = wbank_ff;
                     busy_set[wbank_ff] = 1'b1;
                     wbank_in           = !wbank_ff;
                  end else begin
                     crcf_in   = crcf_ff + 1'b1;
                     q_ev.code = EV_CRC_FAIL;
                  end
               end else begin
                  crc_in = crc8_update(crc_ff, req_in_byte);
               end
            end
            default: begin
               // address byte (unused phase code behaves the same)
               wr_idx    = '0;
               fill_in   = '0;
               target_in = 8'd0;
               crc_in    = 8'd0;
               phase_in  = PH_LEN;
            end
         endcase
         q_ev.good     = 32'(good_in);
         q_ev.crc_fail = 32'(crcf_in);
         q_ev.len_rej  = 32'(lrej_in);
         q_ev.ovf      = 32'(ovf_in);
      end
   end

   assign busy_in     = (busy_ff | busy_set) & ~bank_release;
   assign mem_wr_addr = {wbank_ff, wr_idx};
   assign mem_wr_data = req_in_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RST;
         phase_ff   <= PH_ADDR;
         fill_ff    <= '0;
         target_ff  <= 8'd0;
         crc_ff     <= 8'd0;
         wbank_ff   <= 1'b0;
         busy_ff    <= 2'b00;
         good_ff    <= '0;
         crcf_ff    <= '0;
         lrej_ff    <= '0;
         ovf_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         phase_ff  <= phase_in;
         fill_ff   <= fill_in;
         target_ff <= target_in;
         crc_ff    <= crc_in;
         wbank_ff  <= wbank_in;
         busy_ff   <= busy_in;
         good_ff   <= good_in;
         crcf_ff   <= crcf_in;
         lrej_ff   <= lrej_in;
         ovf_ff    <= ovf_in;
      end
   end

endmodule

// ----- rtl/core/sfd_evq.sv -----
// Two-entry event queue between the front end and the readout.
// Uses sfd_pkg for the entry type.
`timescale 1ns / 1ps

module sfd_evq import sfd_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  ev_type push_ev,
   output logic   full,
   input  logic   pop,
   output logic   head_valid,
   output ev_type head_ev
);

   localparam int EVQ_DEPTH = 2;
   localparam int PTR_W     = $clog2(EVQ_DEPTH);
   localparam int CNT_W     = $clog2(EVQ_DEPTH + 1);

   ev_type           ent_ff [EVQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == CNT_W'(EVQ_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_ev    = ent_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- rtl/core/sfd_back.sv -----
// Readout: takes queued events, reads good frames out of their bank and
// drives the result register. Uses sfd_pkg.
`timescale 1ns / 1ps

module sfd_back import sfd_pkg::*; #(
   parameter int BUF_DEPTH = 64,
   localparam int IDX_W  = $clog2(BUF_DEPTH),
   localparam int FILL_W = $clog2(BUF_DEPTH + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  ev_type         q_ev,
   output logic           q_pop,
   output logic           rd_en,
   output logic [IDX_W:0] rd_addr,
   input  logic [7:0]     rd_data,
   output logic [1:0]     bank_release,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [1:0]     rsp_event_res,
   output logic [7:0]     rsp_frame_byte,
   output logic [5:0]     rsp_byte_index,
   output logic           rsp_last,
   output logic [6:0]     rsp_frame_total,
   output logic [31:0]    rsp_good_count,
   output logic [31:0]    rsp_crc_fail_count,
   output logic [31:0]    rsp_len_reject_count,
   output logic [31:0]    rsp_overflow_count
);

   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic              pend_last_ff, pend_last_in;
   logic [FILL_W-1:0] bk_idx_ff, bk_idx_in;
   logic              out_valid_ff, out_valid_in;
   logic              load;
   logic              out_free;
   logic [1:0]        ld_code;
   logic [7:0]        ld_byte;
   logic [5:0]        ld_index;
   logic              ld_last;
   logic [6:0]        ld_total;

   logic [1:0]  ev_ff;
   logic [7:0]  byte_ff;
   logic [5:0]  index_ff;
   logic        last_ff;
   logic [6:0]  total_ff;
   logic [31:0] good_ff, crcf_ff, lrej_ff, ovf_ff;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      pend_last_in = pend_last_ff;
      bk_idx_in    = bk_idx_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      load         = 1'b0;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = {q_ev.bank, bk_idx_ff[IDX_W-1:0]};
      bank_release = 2'b00;
      ld_code      = EV_GOOD;
      ld_byte      = 8'd0;
      ld_index     = 6'd0;
      ld_last      = 1'b1;
      ld_total     = 7'd0;
      if (pend_ff) begin
         // read data is back; the result register was freed when it was issued
         load         = 1'b1;
         out_valid_in = 1'b1;
         ld_byte      = rd_data;
         ld_index     = 6'(pend_idx_ff);
         ld_last      = pend_last_ff;
         ld_total     = q_ev.total;
         if (pend_last_ff) begin
            q_pop                   = 1'b1;
            bank_release[q_ev.bank] = 1'b1;
            bk_idx_in               = '0;
         end
      end else if (q_valid && out_free) begin
         if (q_ev.code != EV_GOOD) begin
            load         = 1'b1;
            out_valid_in = 1'b1;
            ld_code      = q_ev.code;
            q_pop        = 1'b1;
         end else begin
            rd_en        = 1'b1;
            pend_in      = 1'b1;
            pend_idx_in  = bk_idx_ff[IDX_W-1:0];
            pend_last_in = (7'(bk_idx_ff) + 7'd1 == q_ev.total);
            bk_idx_in    = bk_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         bk_idx_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         bk_idx_ff    <= bk_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff  <= pend_idx_in;
      pend_last_ff <= pend_last_in;
      if (load) begin
         ev_ff    <= ld_code;
         byte_ff  <= ld_byte;
         index_ff <= ld_index;
         last_ff  <= ld_last;
         total_ff <= ld_total;
         good_ff  <= q_ev.good;
         crcf_ff  <= q_ev.crc_fail;
         lrej_ff  <= q_ev.len_rej;
         ovf_ff   <= q_ev.ovf;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_event_res        = ev_ff;
   assign rsp_frame_byte       = byte_ff;
   assign rsp_byte_index       = index_ff;
   assign rsp_last             = last_ff;
   assign rsp_frame_total      = total_ff;
   assign rsp_good_count       = good_ff;
   assign rsp_crc_fail_count   = crcf_ff;
   assign rsp_len_reject_count = lrej_ff;
   assign rsp_overflow_count   = ovf_ff;

endmodule

// ----- rtl/core/serial_frame_deframer_crc8.sv -----
// Serial frame deframer with CRC-8 check: top level.
// Uses sfd_pkg, sfd_front, sfd_evq, sfd_back and sfd_ram.
//
// req_*: one received byte per word (valid/ready). Frames are address,
//   length (2..max_len), then length bytes: type, payload, CRC-8 (0xD5).
// rsp_*: results (valid/ready). A good frame comes out byte by byte from
//   the address on, last set on its final byte; a length reject, CRC
//   failure or buffer overflow gives one status word. Totals ride along.
// csr_*: write-only max_len register, reset value 62.
// Input takes one byte per cycle while the event queue has room and the
//   bank being filled is not still being read out.
// A status word goes through the event queue and the result register;
//   a good frame's bytes go through the queue, the registered RAM read and
//   the result register. Readout issues one RAM read at a time, waiting for its data.
// Two frame banks let the next frame fill while the last one drains.
// Reset clears parser state, totals and queues; no RAM clearing pass.
// A stalled receiver holds the result register; input stalls only once
//   the queue fills or both banks hold unread frames.
`timescale 1ns / 1ps

module serial_frame_deframer_crc8 import sfd_pkg::*; #(
   parameter int BUF_DEPTH   = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_res,
   output logic [7:0]  rsp_frame_byte,
   output logic [5:0]  rsp_byte_index,
   output logic        rsp_last,
   output logic [6:0]  rsp_frame_total,
   output logic [31:0] rsp_good_count,
   output logic [31:0] rsp_crc_fail_count,
   output logic [31:0] rsp_len_reject_count,
   output logic [31:0] rsp_overflow_count
);

   localparam int IDX_W = $clog2(BUF_DEPTH);

   logic           q_full, q_push, q_pop, q_valid;
   ev_type         push_ev, head_ev;
   logic [1:0]     bank_release;
   logic           mem_wr_en, mem_rd_en;
   logic [IDX_W:0] mem_wr_addr, mem_rd_addr;
   logic [7:0]     mem_wr_data, mem_rd_data;

   sfd_front #(
      .BUF_DEPTH   (BUF_DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_ev         (push_ev),
      .bank_release (bank_release),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data)
   );

   sfd_evq u_evq (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ev    (push_ev),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_ev    (head_ev)
   );

   sfd_ram #(
      .WIDTH (8),
      .DEPTH (2 ** (IDX_W + 1))
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sfd_back #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_ev                 (head_ev),
      .q_pop                (q_pop),
      .rd_en                (mem_rd_en),
      .rd_addr              (mem_rd_addr),
      .rd_data              (mem_rd_data),
      .bank_release         (bank_release),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_event_res        (rsp_event_res),
      .rsp_frame_byte       (rsp_frame_byte),
      .rsp_byte_index       (rsp_byte_index),
      .rsp_last             (rsp_last),
      .rsp_frame_total      (rsp_frame_total),
      .rsp_good_count       (rsp_good_count),
      .rsp_crc_fail_count   (rsp_crc_fail_count),
      .rsp_len_reject_count (rsp_len_reject_count),
      .rsp_overflow_count   (rsp_overflow_count)
   );

endmodule

// ----- rtl/core/sfd_checker.sv -----
// Port-level checks on the deframer's result channel, bound to the top level.
// Uses sfd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfd_checker import sfd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_event_res,
   input logic [7:0] rsp_frame_byte,
   input logic [5:0] rsp_byte_index,
   input logic       rsp_last,
   input logic [6:0] rsp_frame_total
);

   `SFD_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid, "rsp_valid high after reset")

   `SFD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res) && $stable(rsp_frame_byte) && $stable(rsp_byte_index), "stalled word changed")

   `SFD_ASSERT(a_status_shape, clock, reset, rsp_valid && rsp_event_res != EV_GOOD |-> rsp_last && rsp_frame_byte == 8'd0 && rsp_byte_index == 6'd0 && rsp_frame_total == 7'd0, "malformed status word")

   `SFD_ASSERT(a_index_in_frame, clock, reset, rsp_valid && rsp_event_res == EV_GOOD |-> 7'(rsp_byte_index) < rsp_frame_total, "frame byte index beyond frame")

   `SFD_ASSERT(a_last_at_end, clock, reset, rsp_valid && rsp_event_res == EV_GOOD |-> rsp_last == (7'(rsp_byte_index) + 7'd1 == rsp_frame_total), "last marker misplaced")

endmodule

bind serial_frame_deframer_crc8 sfd_checker u_sfd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_event_res   (rsp_event_res),
   .rsp_frame_byte  (rsp_frame_byte),
   .rsp_byte_index  (rsp_byte_index),
   .rsp_last        (rsp_last),
   .rsp_frame_total (rsp_frame_total)
);
